// File: rtl/hfd_pkg.sv
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types, constants and helpers for the HTTP/2 frame deframer.
// ----------------------------------------------------------------------------
package hfd_pkg;

    localparam logic [30:0] MASK31   = 31'h7FFF_FFFF;
    localparam logic [31:0] MFS_MIN  = 32'h0000_4000;
    localparam logic [31:0] MFS_MAX  = 32'h00FF_FFFF;
    localparam logic [7:0]  TYPE_MAX = 8'h09;

    localparam int FLAG_PADDED_BIT = 3;
    localparam int FLAG_PRIO_BIT   = 5;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // frame types
    localparam logic [7:0] FT_DATA     = 8'd0;
    localparam logic [7:0] FT_HEADERS  = 8'd1;
    localparam logic [7:0] FT_PRIORITY = 8'd2;
    localparam logic [7:0] FT_RST      = 8'd3;
    localparam logic [7:0] FT_SETTINGS = 8'd4;
    localparam logic [7:0] FT_PROMISE  = 8'd5;
    localparam logic [7:0] FT_PING     = 8'd6;
    localparam logic [7:0] FT_GOAWAY   = 8'd7;
    localparam logic [7:0] FT_WINDOW   = 8'd8;

    localparam logic [15:0] SET_MAX_FRAME_SIZE = 16'd5;

    // result kinds
    localparam logic [2:0] K_HEADER  = 3'd0;
    localparam logic [2:0] K_CONTENT = 3'd1;
    localparam logic [2:0] K_PRIO    = 3'd2;
    localparam logic [2:0] K_SETTING = 3'd3;
    localparam logic [2:0] K_ID      = 3'd4;
    localparam logic [2:0] K_ERRCODE = 3'd5;
    localparam logic [2:0] K_PING    = 3'd6;
    localparam logic [2:0] K_END     = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_BADLEN  = 2'd2;
    localparam logic [1:0] ST_BADPAD  = 2'd3;

    typedef enum logic [3:0] {
        PH_HDR, PH_PADLEN, PH_PRIO, PH_PROMISE, PH_CONTENT, PH_PAD,
        PH_PRIOFRAME, PH_RST, PH_SETTINGS, PH_PING, PH_GOAWAY, PH_WINDOW,
        PH_DRAIN_LEN, PH_DRAIN_PAD, PH_IGNORE
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  frame_type;
        logic [7:0]  flags;
        logic [23:0] length;
        logic [30:0] sid;
        logic        top_bit;
        logic [63:0] word;
        logic [15:0] aux;
        logic [1:0]  status;
        logic        frame_end;
    } result_t;

    // x mod 6 for x below 384, by restoring subtraction
    function automatic logic [2:0] mod6(input logic [8:0] x);
        logic [8:0] v;
        v = x;
        if (v >= 9'd192) v = v - 9'd192;
        if (v >= 9'd96)  v = v - 9'd96;
        if (v >= 9'd48)  v = v - 9'd48;
        if (v >= 9'd24)  v = v - 9'd24;
        if (v >= 9'd12)  v = v - 9'd12;
        if (v >= 9'd6)   v = v - 9'd6;
        return v[2:0];
    endfunction

    // bytes of fixed fields ahead of the content
    function automatic logic [2:0] fixed_need(input logic [7:0] t, input logic [7:0] f);
        logic [2:0] n;
        n = 3'd0;
        if (t == FT_HEADERS && f[FLAG_PRIO_BIT]) n = 3'd5;
        else if (t == FT_PROMISE)               n = 3'd4;
        return n;
    endfunction

endpackage

// File: rtl/hfd_ifs.sv
// ----------------------------------------------------------------------------
// hfd_ifs
// Valid/ready channels: received bytes in, parsed results out.
// ----------------------------------------------------------------------------
interface hfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hfd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [7:0]  out_frame_type;
    logic [7:0]  out_flags;
    logic [23:0] out_length;
    logic [30:0] out_stream_id;
    logic        out_top_bit;
    logic [63:0] out_word;
    logic [15:0] out_aux;
    logic [1:0]  out_status;
    logic        out_frame_end;
    modport source (output valid, output out_kind, output out_frame_type,
                    output out_flags, output out_length, output out_stream_id,
                    output out_top_bit, output out_word, output out_aux,
                    output out_status, output out_frame_end, input ready);
    modport sink   (input valid, input out_kind, input out_frame_type,
                    input out_flags, input out_length, input out_stream_id,
                    input out_top_bit, input out_word, input out_aux,
                    input out_status, input out_frame_end, output ready);
endinterface

// File: rtl/hfd_front.sv
// ----------------------------------------------------------------------------
// hfd_front
// Byte parser: collects the frame header, walks the payload and builds at
// most one result per accepted byte.
// ----------------------------------------------------------------------------
module hfd_front
    import hfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    output logic        have,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  flags_reg, flags_next;
    logic        hres_reg, hres_next;
    logic [30:0] sid_reg, sid_next;
    logic [23:0] len_reg, len_next;
    logic [2:0]  lmod_reg, lmod_next;
    logic [23:0] pcnt_reg, pcnt_next;
    logic [7:0]  pad_reg, pad_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  fidx_reg, fidx_next;
    logic        halted_reg, halted_next;

    logic [23:0] pc1;
    logic [63:0] acc1;
    logic [3:0]  fi1;
    logic [2:0]  need;
    logic [23:0] rem;
    logic        at_end;
    logic        hdr_last;
    logic [24:0] used_fix;
    logic [24:0] used_pad;

    // shared decode
    assign pc1      = pcnt_reg + 24'd1;
    assign acc1     = {acc_reg[55:0], in_byte};
    assign fi1      = fidx_reg + 4'd1;
    assign need     = fixed_need(type_reg, flags_reg);
    assign rem      = len_reg - pc1;
    assign at_end   = (pc1 == len_reg);
    assign hdr_last = (hidx_reg == 4'd8);
    assign used_fix = {1'b0, pc1} + {17'd0, pad_reg};
    assign used_pad = {1'b0, pc1} + {17'd0, in_byte};

    // header register update
    always_comb
    begin
        type_next  = type_reg;
        flags_next = flags_reg;
        hres_next  = hres_reg;
        sid_next   = sid_reg;
        len_next   = len_reg;
        lmod_next  = lmod_reg;
        if (phase_reg == PH_HDR)
        begin
            case (hidx_reg)
                4'd0:
                begin
                    len_next  = {16'd0, in_byte};
                    lmod_next = mod6({1'b0, in_byte});
                end
                4'd1, 4'd2:
                begin
                    len_next  = {len_reg[15:0], in_byte};
                    lmod_next = mod6({4'd0, lmod_reg, 2'd0} + {1'b0, in_byte});
                end
                4'd3: type_next  = in_byte;
                4'd4: flags_next = in_byte;
                4'd5:
                begin
                    hres_next       = in_byte[7];
                    sid_next[30:24] = in_byte[6:0];
                end
                4'd6: sid_next[23:16] = in_byte;
                4'd7: sid_next[15:8]  = in_byte;
                4'd8: sid_next[7:0]   = in_byte;
                default: ;
            endcase
        end
    end

    // next parse state
    always_comb
    begin
        phase_t pnew;
        logic [2:0] nd;
        pnew        = phase_reg;
        nd          = fixed_need(type_next, flags_next);
        hidx_next   = hidx_reg;
        pcnt_next   = pcnt_reg;
        pad_next    = pad_reg;
        acc_next    = acc_reg;
        fidx_next   = fidx_reg;
        halted_next = halted_reg;
        if (phase_reg == PH_HDR)
        begin
            hidx_next = hidx_reg + 4'd1;
            if (hdr_last)
            begin
                hidx_next = 4'd0;
                pcnt_next = 24'd0;
                pad_next  = 8'd0;
                acc_next  = 64'd0;
                fidx_next = 4'd0;
                if (type_next > TYPE_MAX)
                    halted_next = 1'b1;
                else
                begin
                    case (type_next)
                        FT_DATA, FT_HEADERS, FT_PROMISE:
                        begin
                            if (flags_next[FLAG_PADDED_BIT])
                                pnew = (len_next == 24'd0) ? PH_DRAIN_LEN : PH_PADLEN;
                            else if (len_next < {21'd0, nd})
                                pnew = PH_DRAIN_LEN;
                            else if (nd == 3'd5)
                                pnew = PH_PRIO;
                            else if (nd == 3'd4)
                                pnew = PH_PROMISE;
                            else
                                pnew = PH_CONTENT;
                        end
                        FT_PRIORITY: pnew = (len_next == 24'd5) ? PH_PRIOFRAME : PH_DRAIN_LEN;
                        FT_RST:      pnew = (len_next == 24'd4) ? PH_RST : PH_DRAIN_LEN;
                        FT_SETTINGS: pnew = (lmod_next == 3'd0) ? PH_SETTINGS : PH_DRAIN_LEN;
                        FT_PING:     pnew = (len_next >= 24'd8) ? PH_PING : PH_DRAIN_LEN;
                        FT_GOAWAY:   pnew = (len_next >= 24'd8) ? PH_GOAWAY : PH_DRAIN_LEN;
                        FT_WINDOW:   pnew = (len_next >= 24'd4) ? PH_WINDOW : PH_DRAIN_LEN;
                        default:     pnew = PH_CONTENT;
                    endcase
                end
            end
        end
        else
        begin
            pcnt_next = pc1;
            acc_next  = acc1;
            fidx_next = fi1;
            case (phase_reg)
                PH_PADLEN:
                begin
                    pad_next  = in_byte;
                    acc_next  = 64'd0;
                    fidx_next = 4'd0;
                    if (rem < {21'd0, need})
                        pnew = PH_DRAIN_LEN;
                    else if ({16'd0, in_byte} > rem - {21'd0, need})
                        pnew = PH_DRAIN_PAD;
                    else if (need == 3'd5)
                        pnew = PH_PRIO;
                    else if (need == 3'd4)
                        pnew = PH_PROMISE;
                    else
                        pnew = (used_pad < {1'b0, len_reg}) ? PH_CONTENT : PH_PAD;
                end
                PH_PRIO, PH_PRIOFRAME:
                    if (fi1 == 4'd5)
                    begin
                        acc_next  = 64'd0;
                        fidx_next = 4'd0;
                        if (phase_reg == PH_PRIO)
                            pnew = (used_fix < {1'b0, len_reg}) ? PH_CONTENT : PH_PAD;
                    end
                PH_PROMISE, PH_WINDOW:
                    if (fi1 == 4'd4)
                    begin
                        acc_next  = 64'd0;
                        fidx_next = 4'd0;
                        if (phase_reg == PH_PROMISE)
                            pnew = (used_fix < {1'b0, len_reg}) ? PH_CONTENT : PH_PAD;
                        else
                            pnew = PH_IGNORE;
                    end
                PH_RST:
                    if (fi1 == 4'd4)
                    begin
                        acc_next  = 64'd0;
                        fidx_next = 4'd0;
                    end
                PH_SETTINGS:
                    if (fi1 == 4'd6)
                    begin
                        acc_next  = 64'd0;
                        fidx_next = 4'd0;
                    end
                PH_PING:
                    if (fi1 == 4'd8)
                    begin
                        acc_next  = 64'd0;
                        fidx_next = 4'd0;
                        pnew      = PH_IGNORE;
                    end
                PH_GOAWAY:
                    if (fi1 == 4'd8)
                    begin
                        acc_next  = 64'd0;
                        fidx_next = 4'd0;
                        pnew = (used_fix < {1'b0, len_reg}) ? PH_CONTENT : PH_PAD;
                    end
                PH_CONTENT:
                begin
                    acc_next  = 64'd0;
                    fidx_next = 4'd0;
                    if (used_fix >= {1'b0, len_reg})
                        pnew = PH_PAD;
                end
                default:
                begin
                    acc_next  = 64'd0;
                    fidx_next = 4'd0;
                end
            endcase
            if (at_end)
            begin
                acc_next  = 64'd0;
                fidx_next = 4'd0;
            end
        end
        phase_next = pnew;
    end

    // result fields
    always_comb
    begin
        logic [2:0]  kind;
        logic        top;
        logic [63:0] word;
        logic [15:0] aux;
        logic        got;
        logic [1:0]  st;
        logic        fend;
        kind = K_HEADER;
        top  = hres_next;
        word = 64'd0;
        aux  = 16'd0;
        got  = 1'b0;
        st   = ST_OK;
        fend = 1'b0;
        if (phase_reg == PH_HDR)
        begin
            got = hdr_last;
            if (type_next > TYPE_MAX)
            begin
                st   = ST_UNKNOWN;
                fend = 1'b1;
            end
            else if (len_next == 24'd0)
            begin
                st   = (phase_next == PH_DRAIN_LEN) ? ST_BADLEN : ST_OK;
                fend = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_PRIO, PH_PRIOFRAME:
                    if (fi1 == 4'd5)
                    begin
                        kind = K_PRIO;
                        got  = 1'b1;
                        top  = acc1[39];
                        word = {33'd0, acc1[38:8]};
                        aux  = {8'd0, acc1[7:0]};
                    end
                PH_PROMISE, PH_WINDOW:
                    if (fi1 == 4'd4)
                    begin
                        kind = K_ID;
                        got  = 1'b1;
                        top  = acc1[31];
                        word = {33'd0, acc1[30:0]};
                    end
                PH_RST:
                    if (fi1 == 4'd4)
                    begin
                        kind = K_ERRCODE;
                        got  = 1'b1;
                        word = {32'd0, acc1[31:0]};
                    end
                PH_SETTINGS:
                    if (fi1 == 4'd6)
                    begin
                        kind = K_SETTING;
                        got  = 1'b1;
                        aux  = acc1[47:32];
                        word = {32'd0, acc1[31:0]};
                        if (aux == SET_MAX_FRAME_SIZE)
                        begin
                            if (acc1[31:0] < MFS_MIN)
                                word = {32'd0, MFS_MIN};
                            else if (acc1[31:0] > MFS_MAX)
                                word = {32'd0, MFS_MAX};
                        end
                    end
                PH_PING:
                    if (fi1 == 4'd8)
                    begin
                        kind = K_PING;
                        got  = 1'b1;
                        word = acc1;
                    end
                PH_GOAWAY:
                    if (fi1 == 4'd4)
                    begin
                        kind = K_ID;
                        got  = 1'b1;
                        top  = acc1[31];
                        word = {33'd0, acc1[30:0]};
                    end
                    else if (fi1 == 4'd8)
                    begin
                        kind = K_ERRCODE;
                        got  = 1'b1;
                        word = {32'd0, acc1[31:0]};
                    end
                PH_CONTENT:
                begin
                    kind = K_CONTENT;
                    got  = 1'b1;
                    aux  = {8'd0, in_byte};
                end
                default: ;
            endcase
            if (at_end)
            begin
                fend = 1'b1;
                st   = (phase_next == PH_DRAIN_LEN) ? ST_BADLEN :
                       (phase_next == PH_DRAIN_PAD) ? ST_BADPAD : ST_OK;
                if (!got)
                begin
                    kind = K_END;
                    top  = hres_next;
                end
                got = 1'b1;
            end
        end
        have           = got && !halted_reg;
        res.kind       = kind;
        res.frame_type = type_next;
        res.flags      = flags_next;
        res.length     = len_next;
        res.sid        = sid_next;
        res.top_bit    = top;
        res.word       = word;
        res.aux        = aux;
        res.status     = st;
        res.frame_end  = fend;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            hidx_reg   <= 4'd0;
            pcnt_reg   <= 24'd0;
            pad_reg    <= 8'd0;
            acc_reg    <= 64'd0;
            fidx_reg   <= 4'd0;
            halted_reg <= 1'b0;
            type_reg   <= 8'd0;
            flags_reg  <= 8'd0;
            hres_reg   <= 1'b0;
            sid_reg    <= 31'd0;
            len_reg    <= 24'd0;
            lmod_reg   <= 3'd0;
        end
        else if (accept && !halted_reg)
        begin
            phase_reg  <= (at_end && phase_reg != PH_HDR) ||
                          (hdr_last && phase_reg == PH_HDR && len_next == 24'd0)
                          ? PH_HDR : phase_next;
            hidx_reg   <= hidx_next;
            pcnt_reg   <= pcnt_next;
            pad_reg    <= pad_next;
            acc_reg    <= acc_next;
            fidx_reg   <= fidx_next;
            halted_reg <= halted_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            hres_reg   <= hres_next;
            sid_reg    <= sid_next;
            len_reg    <= len_next;
            lmod_reg   <= lmod_next;
        end
    end

endmodule

// File: rtl/hfd_queue.sv
// ----------------------------------------------------------------------------
// hfd_queue
// Short result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module hfd_queue
    import hfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output result_t head
);

    result_t         mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, rd_reg;
    logic [Q_AW:0]   cnt_reg;

    assign full      = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// File: rtl/http2_frame_deframer.sv
// ----------------------------------------------------------------------------
// http2_frame_deframer
// HTTP/2 frame deframer: bytes in, header, field and content results out.
// ----------------------------------------------------------------------------
// One byte is taken every clock while the four-entry result queue has room;
// each byte is parsed in the cycle it is accepted and gives zero or one
// result, which waits in the queue until the output side takes it. The
// parse is a single register stage, so throughput is one byte per cycle and
// results are registered in the queue. After the header of an unknown type,
// no new result is made until reset; bytes are still consumed.
module http2_frame_deframer
    import hfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    hfd_byte_if.sink     stream,
    hfd_result_if.source frames
);

    logic    q_full, q_ne, accept, have, pop;
    result_t res, head;

    assign stream.ready = !q_full;
    assign accept       = stream.valid && !q_full;
    assign pop          = frames.valid && frames.ready;

    hfd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (stream.in_byte),
        .have    (have),
        .res     (res)
    );

    hfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && have),
        .push_data (res),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_ne),
        .head      (head)
    );

    // output channel
    assign frames.valid          = q_ne;
    assign frames.out_kind       = head.kind;
    assign frames.out_frame_type = head.frame_type;
    assign frames.out_flags      = head.flags;
    assign frames.out_length     = head.length;
    assign frames.out_stream_id  = head.sid;
    assign frames.out_top_bit    = head.top_bit;
    assign frames.out_word       = head.word;
    assign frames.out_aux        = head.aux;
    assign frames.out_status     = head.status;
    assign frames.out_frame_end  = head.frame_end;

endmodule

// File: rtl/hfd_checker.sv
// ----------------------------------------------------------------------------
// hfd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module hfd_checker
    import hfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_kind,
    input logic [63:0] out_word,
    input logic [15:0] out_aux,
    input logic [1:0]  out_status,
    input logic        out_frame_end
);

    // an error status only comes with the end of a frame
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_OK |-> out_frame_end)
        else $error("error status without frame end");

    // a bare frame-end result always closes the frame
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == K_END |-> out_frame_end && out_word == 64'd0)
        else $error("frame-end result malformed");

    // header and content results carry no word
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == K_HEADER || out_kind == K_CONTENT)
        |-> out_word == 64'd0)
        else $error("word set on header or content result");

    // aux only used by content, priority and setting results
    a_aux_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != K_CONTENT && out_kind != K_PRIO &&
        out_kind != K_SETTING |-> out_aux == 16'd0)
        else $error("aux set on wrong kind");

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind http2_frame_deframer hfd_checker u_hfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (frames.valid),
    .out_ready     (frames.ready),
    .out_kind      (frames.out_kind),
    .out_word      (frames.out_word),
    .out_aux       (frames.out_aux),
    .out_status    (frames.out_status),
    .out_frame_end (frames.out_frame_end)
);
